>>> src/twoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twoa_pkg;

    localparam int COORD_W   = 24;
    localparam int FRAC_W    = 12;
    localparam int TAG_W     = 16;
    localparam int AREA_W    = 48;
    localparam int AREA_FRAC = 24;
    localparam int VCNT_W    = 3;
    localparam int POLY_CAP  = 64;
    localparam int IDX_W     = $clog2(POLY_CAP);
    localparam int K_W       = IDX_W + 1;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MUL_W     = COORD_W + 2;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int NUM_W     = 2 * COORD_W + 2;
    localparam int SUM_W     = 2 * COORD_W + 10;
    localparam int EXT_W     = SUM_W + AREA_W + AREA_FRAC;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    typedef enum logic [1:0] {
        REG_MIN_X = 2'd0,
        REG_MIN_Y = 2'd1,
        REG_MAX_X = 2'd2,
        REG_MAX_Y = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PASS,
        ST_SRD,
        ST_ERD,
        ST_EVAL,
        ST_DSTART,
        ST_DIV,
        ST_XWR,
        ST_INWR,
        ST_NEXT,
        ST_ABASE,
        ST_AB0,
        ST_AREAD,
        ST_M1,
        ST_M2,
        ST_ACC,
        ST_FIN
    } seq_state_t;

    typedef struct packed {
        logic        [TAG_W-1:0]   face_tag;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } tri_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag_out;
        logic [AREA_W-1:0] overlap_area;
        logic [VCNT_W-1:0] clip_vertices;
    } res_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } vertex_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        vertex_t           wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_ctl_t;

endpackage

`default_nettype wire

>>> src/twoa_vtx_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module twoa_vtx_ram (
    input  wire logic               clk,
    input  wire twoa_pkg::ram_ctl_t ctl,
    output twoa_pkg::vertex_t       rd_data
);

    twoa_pkg::vertex_t mem [2*twoa_pkg::POLY_CAP];
    twoa_pkg::vertex_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rd_data_reg <= mem[ctl.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/twoa_div.sv
`timescale 1ns / 1ps
`default_nettype none

module twoa_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [twoa_pkg::NUM_W-1:0]    num,
    input  wire logic [twoa_pkg::DIFF_W-1:0]   den,
    output logic                               done,
    output logic [twoa_pkg::DIFF_W-1:0]        quo
);

    localparam int QW  = twoa_pkg::DIFF_W;
    localparam int CW  = $clog2(QW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0] rem_reg, rem_next;
    logic [QW-1:0] sh_reg, sh_next;
    logic [QW-1:0] den_reg, den_next;
    logic [QW:0]   trial;
    logic          fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    // one quotient bit a cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, sh_reg[QW-1]};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            rem_next  = num[twoa_pkg::NUM_W-1:QW];
            sh_next   = num[QW-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? QW'(trial - {1'b0, den_reg}) : trial[QW-1:0];
            sh_next  = {sh_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

`default_nettype wire

>>> src/triangle_window_overlap_area.sv
`timescale 1ns / 1ps
`default_nettype none

// Clips each triangle item against the window held in the four APB registers
// (x min, x max, y min, y max passes, edges inside) and returns the overlap
// area with 24 fractional bits, saturating, plus the clipped vertex count and
// the echoed tag. One item is in work at a time; tri_ready is low from accept
// until the result is loaded into the output register. Once a pass leaves no
// vertex the item skips the remaining passes and ends. Each crossing waits on
// the shared divider, which yields one quotient bit a cycle, and each pass
// reads its vertices one by one from the vertex memory, which has one write
// port and one read port.

module triangle_window_overlap_area (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           tri_valid,
    output logic                                tri_ready,
    input  wire twoa_pkg::tri_item_t            tri_item,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output twoa_pkg::res_item_t                 res_item,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [twoa_pkg::APB_AW-1:0]    paddr,
    input  wire logic [twoa_pkg::APB_DW-1:0]    pwdata,
    output logic [twoa_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int C  = twoa_pkg::COORD_W;
    localparam int DW = twoa_pkg::DIFF_W;
    localparam int KW = twoa_pkg::K_W;
    localparam int IW = twoa_pkg::IDX_W;
    localparam logic [twoa_pkg::VCNT_W-1:0] VCNT_MAX = '1;

    logic signed [C-1:0] win_min_x_reg, win_min_y_reg, win_max_x_reg, win_max_y_reg;
    twoa_pkg::reg_idx_t  apb_idx;

    twoa_pkg::seq_state_t state_reg, state_next;
    logic                 res_valid_reg, res_valid_next;
    twoa_pkg::res_item_t  res_item_reg, res_item_next;
    twoa_pkg::tri_item_t  tri_reg, tri_next;
    logic [1:0]           load_cnt_reg, load_cnt_next;
    logic [1:0]           pass_reg, pass_next;
    logic                 src_reg, src_next;
    logic [KW-1:0]        n_reg, n_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [KW-1:0]        i_reg, i_next;
    twoa_pkg::vertex_t    s_reg, s_next, e_reg, e_next;
    twoa_pkg::vertex_t    base_reg, base_next, prev_reg, prev_next, cur_reg, cur_next;
    logic signed [twoa_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [twoa_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic                 neg_reg, neg_next;
    logic                 wzero_reg, wzero_next;
    logic                 ein_reg, ein_next;

    twoa_pkg::ram_ctl_t   ram_ctl;
    twoa_pkg::vertex_t    ram_rd;
    logic                 div_start, div_done;
    logic [DW-1:0]        div_quo;

    logic                 axis, keep_ge;
    logic signed [C-1:0]  bound, su, sv, eu, ev;
    logic                 s_in, e_in;
    logic signed [DW-1:0] dd, tt, ww;
    logic [DW-1:0]        mag_d, mag_t, mag_w;
    logic signed [DW-1:0] px, py, cxd, cyd;
    logic signed [twoa_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [twoa_pkg::PROD_W-1:0] mul_p;
    logic signed [DW:0]   xv;
    logic signed [C-1:0]  xing;
    logic [twoa_pkg::SUM_W-1:0] abs_sum;
    logic [twoa_pkg::EXT_W-1:0] ext_sum;
    logic [twoa_pkg::EXT_W-1:0] sh_sum;
    logic [twoa_pkg::AREA_W-1:0] area;

    // configuration port
    assign pready  = 1'b1;
    assign apb_idx = twoa_pkg::reg_idx_t'(paddr[twoa_pkg::APB_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_min_x_reg <= '0;
            win_min_y_reg <= '0;
            win_max_x_reg <= '0;
            win_max_y_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (apb_idx)
                twoa_pkg::REG_MIN_X: win_min_x_reg <= pwdata[C-1:0];
                twoa_pkg::REG_MIN_Y: win_min_y_reg <= pwdata[C-1:0];
                twoa_pkg::REG_MAX_X: win_max_x_reg <= pwdata[C-1:0];
                twoa_pkg::REG_MAX_Y: win_max_y_reg <= pwdata[C-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (apb_idx)
            twoa_pkg::REG_MIN_X: prdata = twoa_pkg::APB_DW'(win_min_x_reg);
            twoa_pkg::REG_MIN_Y: prdata = twoa_pkg::APB_DW'(win_min_y_reg);
            twoa_pkg::REG_MAX_X: prdata = twoa_pkg::APB_DW'(win_max_x_reg);
            twoa_pkg::REG_MAX_Y: prdata = twoa_pkg::APB_DW'(win_max_y_reg);
            default:             prdata = '0;
        endcase
    end

    twoa_vtx_ram u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .rd_data (ram_rd)
    );

    twoa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg[twoa_pkg::NUM_W-1:0]),
        .den   (mag_w),
        .done  (div_done),
        .quo   (div_quo)
    );

    // clip edge geometry
    always_comb
    begin
        axis    = pass_reg[1];
        keep_ge = ~pass_reg[0];
        case (pass_reg)
            2'd0:    bound = win_min_x_reg;
            2'd1:    bound = win_max_x_reg;
            2'd2:    bound = win_min_y_reg;
            default: bound = win_max_y_reg;
        endcase
        su    = axis ? s_reg.y : s_reg.x;
        sv    = axis ? s_reg.x : s_reg.y;
        eu    = axis ? e_reg.y : e_reg.x;
        ev    = axis ? e_reg.x : e_reg.y;
        s_in  = keep_ge ? (su >= bound) : (su <= bound);
        e_in  = keep_ge ? (eu >= bound) : (eu <= bound);
        dd    = DW'(ev) - DW'(sv);
        tt    = DW'(bound) - DW'(su);
        ww    = DW'(eu) - DW'(su);
        mag_d = dd[DW-1] ? DW'(-dd) : DW'(dd);
        mag_t = tt[DW-1] ? DW'(-tt) : DW'(tt);
        mag_w = ww[DW-1] ? DW'(-ww) : DW'(ww);
        px    = DW'(prev_reg.x) - DW'(base_reg.x);
        py    = DW'(prev_reg.y) - DW'(base_reg.y);
        cxd   = DW'(cur_reg.x) - DW'(base_reg.x);
        cyd   = DW'(cur_reg.y) - DW'(base_reg.y);
        xv    = neg_reg ? ((DW+1)'(sv) - $signed({1'b0, div_quo}))
                        : ((DW+1)'(sv) + $signed({1'b0, div_quo}));
        xing  = wzero_reg ? sv : xv[C-1:0];
    end

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            twoa_pkg::ST_M1:
            begin
                mul_a = twoa_pkg::MUL_W'(px);
                mul_b = twoa_pkg::MUL_W'(cyd);
            end
            twoa_pkg::ST_M2:
            begin
                mul_a = twoa_pkg::MUL_W'(cxd);
                mul_b = twoa_pkg::MUL_W'(py);
            end
            default:
            begin
                mul_a = $signed({1'b0, mag_d});
                mul_b = $signed({1'b0, mag_t});
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // area scaling and saturation
    always_comb
    begin
        abs_sum = sum_reg[twoa_pkg::SUM_W-1] ? twoa_pkg::SUM_W'(-sum_reg)
                                             : twoa_pkg::SUM_W'(sum_reg);
        ext_sum = {{twoa_pkg::AREA_W{1'b0}}, abs_sum, {twoa_pkg::AREA_FRAC{1'b0}}};
        sh_sum  = ext_sum >> (2 * twoa_pkg::FRAC_W + 1);
        if (n_reg < KW'(3))
        begin
            area = '0;
        end
        else if (|sh_sum[twoa_pkg::EXT_W-1:twoa_pkg::AREA_W])
        begin
            area = '1;
        end
        else
        begin
            area = sh_sum[twoa_pkg::AREA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twoa_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
            load_cnt_reg  <= '0;
            pass_reg      <= '0;
            src_reg       <= 1'b0;
            n_reg         <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            load_cnt_reg  <= load_cnt_next;
            pass_reg      <= pass_next;
            src_reg       <= src_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
        tri_reg      <= tri_next;
        s_reg        <= s_next;
        e_reg        <= e_next;
        base_reg     <= base_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        prod_reg     <= prod_next;
        sum_reg      <= sum_next;
        neg_reg      <= neg_next;
        wzero_reg    <= wzero_next;
        ein_reg      <= ein_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_item_next  = res_item_reg;
        tri_next       = tri_reg;
        load_cnt_next  = load_cnt_reg;
        pass_next      = pass_reg;
        src_next       = src_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        base_next      = base_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        neg_next       = neg_reg;
        wzero_next     = wzero_reg;
        ein_next       = ein_reg;
        tri_ready      = 1'b0;
        div_start      = 1'b0;
        ram_ctl.we     = 1'b0;
        ram_ctl.waddr  = {~src_reg, k_reg[IW-1:0]};
        ram_ctl.wdata  = e_reg;
        ram_ctl.raddr  = {src_reg, i_reg[IW-1:0]};

        unique case (state_reg)
            twoa_pkg::ST_IDLE:
            begin
                tri_ready = 1'b1;
                if (tri_valid)
                begin
                    tri_next      = tri_item;
                    load_cnt_next = '0;
                    src_next      = 1'b0;
                    state_next    = twoa_pkg::ST_LOAD;
                end
            end
            twoa_pkg::ST_LOAD:
            begin
                ram_ctl.we    = 1'b1;
                ram_ctl.waddr = {1'b0, IW'(load_cnt_reg)};
                case (load_cnt_reg)
                    2'd0:    ram_ctl.wdata = twoa_pkg::vertex_t'{x: tri_reg.ax, y: tri_reg.ay};
                    2'd1:    ram_ctl.wdata = twoa_pkg::vertex_t'{x: tri_reg.bx,
                                                                 y: tri_reg.by_coord};
                    default: ram_ctl.wdata = twoa_pkg::vertex_t'{x: tri_reg.cx, y: tri_reg.cy};
                endcase
                load_cnt_next = load_cnt_reg + 2'd1;
                if (load_cnt_reg == 2'd2)
                begin
                    n_next     = KW'(3);
                    pass_next  = '0;
                    state_next = twoa_pkg::ST_PASS;
                end
            end
            twoa_pkg::ST_PASS:
            begin
                k_next        = '0;
                i_next        = '0;
                ram_ctl.raddr = {src_reg, IW'(n_reg - KW'(1))};
                state_next    = (n_reg == '0) ? twoa_pkg::ST_FIN : twoa_pkg::ST_SRD;
            end
            twoa_pkg::ST_SRD:
            begin
                s_next     = ram_rd;
                state_next = twoa_pkg::ST_ERD;
            end
            twoa_pkg::ST_ERD:
            begin
                e_next     = ram_rd;
                state_next = twoa_pkg::ST_EVAL;
            end
            twoa_pkg::ST_EVAL:
            begin
                prod_next  = mul_p;
                neg_next   = dd[DW-1] ^ tt[DW-1] ^ ww[DW-1];
                wzero_next = (ww == '0);
                ein_next   = e_in;
                if ((s_in != e_in) && (k_reg < KW'(twoa_pkg::POLY_CAP)))
                begin
                    state_next = twoa_pkg::ST_DSTART;
                end
                else if (e_in && (k_reg < KW'(twoa_pkg::POLY_CAP)))
                begin
                    state_next = twoa_pkg::ST_INWR;
                end
                else
                begin
                    state_next = twoa_pkg::ST_NEXT;
                end
            end
            twoa_pkg::ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = twoa_pkg::ST_DIV;
            end
            twoa_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = twoa_pkg::ST_XWR;
                end
            end
            twoa_pkg::ST_XWR:
            begin
                ram_ctl.we    = 1'b1;
                ram_ctl.wdata = axis ? twoa_pkg::vertex_t'{x: xing, y: bound}
                                     : twoa_pkg::vertex_t'{x: bound, y: xing};
                k_next        = k_reg + KW'(1);
                if (ein_reg && ((k_reg + KW'(1)) < KW'(twoa_pkg::POLY_CAP)))
                begin
                    state_next = twoa_pkg::ST_INWR;
                end
                else
                begin
                    state_next = twoa_pkg::ST_NEXT;
                end
            end
            twoa_pkg::ST_INWR:
            begin
                ram_ctl.we = 1'b1;
                k_next     = k_reg + KW'(1);
                state_next = twoa_pkg::ST_NEXT;
            end
            twoa_pkg::ST_NEXT:
            begin
                s_next        = e_reg;
                i_next        = i_reg + KW'(1);
                ram_ctl.raddr = {src_reg, IW'(i_reg + KW'(1))};
                if ((i_reg + KW'(1)) < n_reg)
                begin
                    state_next = twoa_pkg::ST_ERD;
                end
                else
                begin
                    n_next    = k_reg;
                    src_next  = ~src_reg;
                    pass_next = pass_reg + 2'd1;
                    state_next = (pass_reg == 2'd3) ? twoa_pkg::ST_ABASE
                                                    : twoa_pkg::ST_PASS;
                end
            end
            twoa_pkg::ST_ABASE:
            begin
                sum_next      = '0;
                ram_ctl.raddr = {src_reg, {IW{1'b0}}};
                state_next    = (n_reg < KW'(3)) ? twoa_pkg::ST_FIN : twoa_pkg::ST_AB0;
            end
            twoa_pkg::ST_AB0:
            begin
                base_next     = ram_rd;
                prev_next     = ram_rd;
                i_next        = KW'(1);
                ram_ctl.raddr = {src_reg, IW'(1)};
                state_next    = twoa_pkg::ST_AREAD;
            end
            twoa_pkg::ST_AREAD:
            begin
                cur_next   = (i_reg == n_reg) ? base_reg : ram_rd;
                state_next = twoa_pkg::ST_M1;
            end
            twoa_pkg::ST_M1:
            begin
                prod_next  = mul_p;
                state_next = twoa_pkg::ST_M2;
            end
            twoa_pkg::ST_M2:
            begin
                sum_next   = sum_reg + twoa_pkg::SUM_W'(prod_reg);
                prod_next  = mul_p;
                state_next = twoa_pkg::ST_ACC;
            end
            twoa_pkg::ST_ACC:
            begin
                sum_next      = sum_reg - twoa_pkg::SUM_W'(prod_reg);
                prev_next     = cur_reg;
                i_next        = i_reg + KW'(1);
                ram_ctl.raddr = {src_reg, IW'(i_reg + KW'(1))};
                state_next    = (i_reg == n_reg) ? twoa_pkg::ST_FIN : twoa_pkg::ST_AREAD;
            end
            twoa_pkg::ST_FIN:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next              = 1'b1;
                    res_item_next.tag_out       = tri_reg.face_tag;
                    res_item_next.overlap_area  = area;
                    res_item_next.clip_vertices = (n_reg > KW'(7)) ? VCNT_MAX
                                                                  : n_reg[2:0];
                    state_next                  = twoa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = twoa_pkg::ST_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

>>> src/twoa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module twoa_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                tri_valid,
    input wire logic                tri_ready,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire twoa_pkg::res_item_t res_item,
    input wire logic                pready
);

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (tri_valid && tri_ready) |=> !tri_ready)
        else $error("input taken while an item is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (tri_valid && tri_ready) |=> !$rose(res_valid))
        else $error("result appeared straight after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.clip_vertices < 3'd3) |-> (res_item.overlap_area == '0))
        else $error("nonzero area with fewer than three vertices");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_item)))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind triangle_window_overlap_area twoa_checker u_twoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tri_valid (tri_valid),
    .tri_ready (tri_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .pready    (pready)
);

`default_nettype wire
